FILE: design/gb3_pkg.sv
package gb3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    // weighted sum peaks at 16 * 255, weight sum at 16
    localparam int SUM_W     = 12;
    localparam int WSUM_W    = 5;
    localparam int DIV_CNT_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_OUT
    } gb3_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

FILE: design/gb3_line_ram.sv
module gb3_line_ram #(
    parameter int DEPTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [$clog2(DEPTH)-1:0]            rd_addr,
    output logic [gb3_pkg::PIX_W-1:0]           rd_data,
    input  logic                                wr_en,
    input  logic [$clog2(DEPTH)-1:0]            wr_addr,
    input  logic [gb3_pkg::PIX_W-1:0]           wr_data
);
    import gb3_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/gb3_divider.sv
module gb3_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gb3_pkg::SUM_W-1:0]    dividend,
    input  logic [gb3_pkg::WSUM_W-1:0]   divisor,
    output gb3_pkg::div_status_t         status,
    output logic [gb3_pkg::SUM_W-1:0]    quotient
);
    import gb3_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]     num_reg;
    logic [SUM_W-1:0]     quo_reg;
    logic [WSUM_W-1:0]    rem_reg;
    logic [WSUM_W-1:0]    divisor_reg;

    logic [WSUM_W:0]      trial;
    logic                 q_bit;
    logic [WSUM_W-1:0]    rem_step;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        trial    = {rem_reg, num_reg[SUM_W-1]};
        q_bit    = (trial >= {1'b0, divisor_reg});
        rem_step = q_bit ? WSUM_W'(trial - {1'b0, divisor_reg}) : trial[WSUM_W-1:0];
    end

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = DIV_CNT_W'(SUM_W - 1);
        end
        else if (busy_reg)
        begin
            count_next = count_reg - 1'b1;
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg     <= dividend;
            divisor_reg <= divisor;
            rem_reg     <= '0;
            quo_reg     <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[SUM_W-2:0], 1'b0};
            rem_reg <= rem_step;
            quo_reg <= {quo_reg[SUM_W-2:0], q_bit};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

FILE: design/gaussian_blur_3x3_edge_renorm_core.sv
// Flow: an accepted item is read from the line buffers, then goes through
// ST_READ; an item that yields a result then waits in ST_DIV on the bit-serial
// divider and in ST_OUT for the output register. No new item is taken before
// the block is back in ST_IDLE; a drain ignored in the pixel phase stays there.
// Reset: counters, window and registers cleared or set to 640 x 480 at once;
// the line memories are not cleared, their stale entries are always masked.
module gaussian_blur_3x3_edge_renorm_core #(
    parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gb3_pkg::PIX_W-1:0]          pixel_in,
    input  logic                               drain,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gb3_pkg::PIX_W-1:0]          pixel_out,
    output logic                               end_of_frame,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gb3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gb3_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import gb3_pkg::*;

    // column index, effective width, and a width wide enough to clamp in
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int EW    = (WW > WIDTH_W) ? WW : WIDTH_W;
    // input rows run to height+1 during the drain
    localparam int ROW_W = HEIGHT_W + 1;

    gb3_state_t state_reg, state_next;

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CW-1:0]       in_column_reg, in_column_next;
    logic [ROW_W-1:0]    in_row_reg, in_row_next;
    logic [CW-1:0]       out_column_reg, out_column_next;
    logic [HEIGHT_W-1:0] out_row_reg, out_row_next;
    logic [PIX_W-1:0]    win_reg [9];
    logic [PIX_W-1:0]    win_next [9];
    logic [PIX_W-1:0]    value_reg;
    logic                eof_pend_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    pixel_out_reg;
    logic                eof_out_reg;

    logic [EW-1:0]       width_ext;
    logic [WW-1:0]       w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    logic                in_fire, cfg_fire, cfg_restart;
    logic                pixel_phase, ignore_item, take_item;
    logic [PIX_W-1:0]    top_pix, mid_pix;
    logic                emit, eof;
    logic                r0_en, r2_en, c0_en, c2_en;
    logic [9:0]          row_sum [3];
    logic [SUM_W-1:0]    sum;
    logic [2:0]          row_weight, col_weight;
    logic [WSUM_W-1:0]   wsum;
    logic [WW-1:0]       in_col_inc, out_col_inc;
    logic                div_start, out_load;
    div_status_t         div_stat;
    logic [SUM_W-1:0]    quotient;

    // ---------------------------------------------------------------------
    // Effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
    // ---------------------------------------------------------------------
    assign width_ext = EW'(width_reg);

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = WW'(1);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = WW'(width_ext);
        end
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    // ---------------------------------------------------------------------
    // Handshakes. Take configuration only while idle, ahead of a pixel.
    // A pending output item does not block the next input item.
    // ---------------------------------------------------------------------
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign in_ready    = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign in_fire     = in_valid && in_ready;
    assign cfg_restart = cfg_fire &&
                         ((cfg_index == CFG_IMAGE_WIDTH) || (cfg_index == CFG_IMAGE_HEIGHT));

    // during the pixel phase a drain item is dropped; afterwards every item
    // drains and its pixel value is replaced by zero
    assign pixel_phase = (in_row_reg < ROW_W'(h_eff));
    assign ignore_item = pixel_phase && drain;
    assign take_item   = in_fire && !ignore_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            value_reg <= pixel_phase ? pixel_in : '0;
        end
    end

    // ---------------------------------------------------------------------
    // Line buffers: read at the accepting edge, write back in the next cycle.
    // Items are handled one at a time, so a write always lands before the
    // next read of the same column, even for a one-pixel-wide image.
    // ---------------------------------------------------------------------
    logic ram_we;
    assign ram_we = (state_reg == ST_READ);

    gb3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_upper_ram (
        .clk     (clk),
        .rd_en   (take_item),
        .rd_addr (in_column_reg),
        .rd_data (top_pix),
        .wr_en   (ram_we),
        .wr_addr (in_column_reg),
        .wr_data (mid_pix)
    );

    gb3_line_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_lower_ram (
        .clk     (clk),
        .rd_en   (take_item),
        .rd_addr (in_column_reg),
        .rd_data (mid_pix),
        .wr_en   (ram_we),
        .wr_addr (in_column_reg),
        .wr_data (value_reg)
    );

    // ---------------------------------------------------------------------
    // Window shift and border-masked weighted sum.
    // The window after the shift serves every output: when the input column
    // is zero the output sits in the last column, where the right-hand
    // column is masked anyway.
    // ---------------------------------------------------------------------
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r*3 + 0] = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = top_pix;
        win_next[5] = mid_pix;
        win_next[8] = value_reg;
    end

    assign emit  = (in_row_reg >= ROW_W'(2)) ||
                   ((in_row_reg == ROW_W'(1)) && (in_column_reg != '0));
    assign r0_en = (out_row_reg != '0);
    assign r2_en = (({1'b0, out_row_reg} + 1'b1) < {1'b0, h_eff});
    assign c0_en = (out_column_reg != '0);
    assign out_col_inc = WW'(out_column_reg) + 1'b1;
    assign c2_en = (out_col_inc < w_eff);
    assign eof   = (out_row_reg == h_eff - 1'b1) && (out_col_inc == w_eff);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = (c0_en ? 10'(win_next[r*3 + 0]) : 10'd0)
                       + {1'b0, win_next[r*3 + 1], 1'b0}
                       + (c2_en ? 10'(win_next[r*3 + 2]) : 10'd0);
        end
        sum = (r0_en ? SUM_W'(row_sum[0]) : '0)
            + SUM_W'({row_sum[1], 1'b0})
            + (r2_en ? SUM_W'(row_sum[2]) : '0);
        row_weight = 3'd2 + {2'b00, r0_en} + {2'b00, r2_en};
        col_weight = 3'd2 + {2'b00, c0_en} + {2'b00, c2_en};
        wsum       = WSUM_W'(row_weight) * WSUM_W'(col_weight);
    end

    assign div_start = (state_reg == ST_READ) && emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (state_reg == ST_READ)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            eof_pend_reg <= eof;
        end
    end

    // ---------------------------------------------------------------------
    // Position counters: input once per taken item, output once per result;
    // both restart on the last pixel of a frame and on a size write.
    // ---------------------------------------------------------------------
    assign in_col_inc = WW'(in_column_reg) + 1'b1;

    always_comb
    begin
        in_column_next  = in_column_reg;
        in_row_next     = in_row_reg;
        out_column_next = out_column_reg;
        out_row_next    = out_row_reg;
        if (cfg_restart)
        begin
            in_column_next  = '0;
            in_row_next     = '0;
            out_column_next = '0;
            out_row_next    = '0;
        end
        else if (state_reg == ST_READ)
        begin
            if (in_col_inc >= w_eff)
            begin
                in_column_next = '0;
                in_row_next    = in_row_reg + 1'b1;
            end
            else
            begin
                in_column_next = CW'(in_col_inc);
            end
            if (emit)
            begin
                if (out_col_inc >= w_eff)
                begin
                    out_column_next = '0;
                    out_row_next    = out_row_reg + 1'b1;
                end
                else
                begin
                    out_column_next = CW'(out_col_inc);
                end
                if (eof)
                begin
                    in_column_next  = '0;
                    in_row_next     = '0;
                    out_column_next = '0;
                    out_row_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg  <= '0;
            in_row_reg     <= '0;
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
        else
        begin
            in_column_reg  <= in_column_next;
            in_row_reg     <= in_row_next;
            out_column_reg <= out_column_next;
            out_row_reg    <= out_row_next;
        end
    end

    // ---------------------------------------------------------------------
    // Renormalising divide: sum over the weights actually used
    // ---------------------------------------------------------------------
    gb3_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .divisor  (wsum),
        .status   (div_stat),
        .quotient (quotient)
    );

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_item)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = emit ? ST_DIV : ST_IDLE;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register is free or being emptied
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_out_reg <= quotient[PIX_W-1:0];
            eof_out_reg   <= eof_pend_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_out    = pixel_out_reg;
    assign end_of_frame = eof_out_reg;

`ifndef NO_ASSERTIONS
    // a new division never starts over one in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    // waiting on the divider implies the divider is working or finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // the input column always addresses a column inside the row
    assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(in_column_reg) < w_eff))
        else $error("input column beyond image width");

    // a size write restarts the frame
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_restart |=> ((in_row_reg == '0) && (in_column_reg == '0) &&
                         (out_row_reg == '0) && (out_column_reg == '0)))
        else $error("frame not restarted after size write");
`endif

endmodule

FILE: verif/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import gb3_pkg::*;

    // Clock, run length and pacing.
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    // Watchdog limit, several times the slowest correct run.
    localparam int LIMIT_CYCLES  = 1000000;
    // Give items that release nothing time to clear.
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int TAIL_START    = 1000;

    localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEFAULT;
    localparam int unsigned KERNEL [9] = '{1, 2, 1, 2, 4, 2, 1, 2, 1};

    // Indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic             eof;
    } blur_item_t;

    // ROW_KNOWN rows carry a result typed in by hand; ROW_ITEM rows go to the predictor.
    typedef enum logic [1:0] {
        ROW_REG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      pix;
        logic                  drn;
        logic [PIX_W-1:0]      want_pix;
        logic                  want_eof;
    } dir_row_t;

    localparam int N_DIRECTED = 35;

    localparam dir_row_t DIRECTED [N_DIRECTED] = '{
        // 2x2 frame of full white; width written with bit 12 set, which is dropped
        '{ROW_REG,   CFG_IMAGE_WIDTH,  13'h1002, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd2,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        // drain while pixels are still due: ignored
        '{ROW_ITEM,  2'd0,             13'd0,    8'hA5,  1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd255, 1'b0, 8'd255, 1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd0,   1'b1, 8'd255, 1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd255, 1'b1, 8'd255, 1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd0,   1'b1, 8'd255, 1'b1},
        // single pixel image: only the centre weight survives
        '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd1,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd1,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd200, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b1, 8'd0,   1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd0,   1'b1, 8'd200, 1'b1},
        // zero width and height clamp to one; a pixel in the drain phase acts as a drain
        '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd77,  1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd13,  1'b0, 8'd0,   1'b0},
        '{ROW_KNOWN, 2'd0,             13'd0,    8'd0,   1'b1, 8'd77,  1'b1},
        // unmapped indexes, then a 3x2 checkerboard left to the predictor
        '{ROW_REG,   CFG_SPARE_B,      13'h1FFF, 8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_SPARE_A,      13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_IMAGE_WIDTH,  13'd3,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_REG,   CFG_IMAGE_HEIGHT, 13'd2,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd255, 1'b0, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'hFF,  1'b1, 8'd0,   1'b0},
        '{ROW_ITEM,  2'd0,             13'd0,    8'd0,   1'b1, 8'd0,   1'b0}
    };

    // DUT connections; every input starts at a known value.
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_in     = '0;
    logic                  drain        = 1'b0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  end_of_frame;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    // Blurred items still owed by the block, oldest first.
    blur_item_t pending_q [$];
    int         err_count  = 0;
    int         rand_items = 0;
    bit         no_idle    = 1'b0;
    bit         hold_req   = 1'b0;

    // Predictor state; line stores start at zero, their stale entries are always masked.
    logic [PIX_W-1:0]    mdl_upper [LINE_DEPTH] = '{default: '0};
    logic [PIX_W-1:0]    mdl_lower [LINE_DEPTH] = '{default: '0};
    logic [PIX_W-1:0]    mdl_win [9]            = '{default: '0};
    int unsigned         mdl_in_col  = 0;
    int unsigned         mdl_in_row  = 0;
    int unsigned         mdl_out_col = 0;
    int unsigned         mdl_out_row = 0;
    logic [WIDTH_W-1:0]  mdl_width   = WIDTH_RESET;
    logic [HEIGHT_W-1:0] mdl_height  = HEIGHT_RESET;

    gaussian_blur_3x3_edge_renorm_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .drain        (drain),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .pixel_out    (pixel_out),
        .end_of_frame (end_of_frame),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Effective frame size: width clamped to 1..LINE_DEPTH, zero height taken as one row.
    function automatic int unsigned cur_width();
        int unsigned w;
        w = mdl_width;
        if (w < 1) w = 1;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned cur_height();
        return (mdl_height < 1) ? 1 : mdl_height;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic restart_counters();
        mdl_in_col  = 0;
        mdl_in_row  = 0;
        mdl_out_col = 0;
        mdl_out_row = 0;
    endtask

    // Advance the predictor by one accepted item. taken is low for a drain that the
    // block ignores; produced says whether the item releases a blurred pixel.
    task automatic blur_predict(input logic [PIX_W-1:0] pix, input logic drn,
                                output bit taken, output bit produced,
                                output blur_item_t res);
        int unsigned w, h, col, sum, wsum;
        int k, r, c;
        logic [PIX_W-1:0] value, top, mid;
        logic [PIX_W-1:0] prev [9];
        logic [PIX_W-1:0] used [9];
        bit eof;
        w        = cur_width();
        h        = cur_height();
        col      = mdl_in_col;
        taken    = !(mdl_in_row < h && drn);
        produced = 1'b0;
        res      = '0;
        eof      = 1'b0;
        if (!taken) return;

        // past the last row every item is a drain and feeds in zero
        value = (mdl_in_row < h) ? pix : 8'd0;
        prev  = mdl_win;
        top   = mdl_upper[col];
        mid   = mdl_lower[col];
        mdl_upper[col] = mid;
        mdl_lower[col] = value;
        for (k = 0; k < 3; k++) begin
            mdl_win[k*3]   = mdl_win[k*3+1];
            mdl_win[k*3+1] = mdl_win[k*3+2];
        end
        mdl_win[2] = top;
        mdl_win[5] = mid;
        mdl_win[8] = value;

        if (mdl_in_row >= 2 || (mdl_in_row == 1 && mdl_in_col >= 1)) begin
            // at column zero the pixel due is the last of an earlier row:
            // take the window from before the shift, moved one column left
            if (col == 0) begin
                for (k = 0; k < 3; k++) begin
                    used[k*3]   = prev[k*3+1];
                    used[k*3+1] = prev[k*3+2];
                    used[k*3+2] = 8'd0;
                end
            end else begin
                used = mdl_win;
            end
            sum  = 0;
            wsum = 0;
            for (r = 0; r < 3; r++) begin
                for (c = 0; c < 3; c++) begin
                    if (!((r == 0 && mdl_out_row < 1) || (r == 2 && mdl_out_row + 1 >= h) ||
                          (c == 0 && mdl_out_col < 1) || (c == 2 && mdl_out_col + 1 >= w))) begin
                        sum  += used[r*3+c] * KERNEL[r*3+c];
                        wsum += KERNEL[r*3+c];
                    end
                end
            end
            eof      = (mdl_out_row == h - 1 && mdl_out_col == w - 1);
            res.pix  = 8'(sum / wsum);
            res.eof  = eof;
            produced = 1'b1;
            mdl_out_col++;
            if (mdl_out_col >= w) begin
                mdl_out_col = 0;
                mdl_out_row++;
            end
        end

        mdl_in_col++;
        if (mdl_in_col >= w) begin
            mdl_in_col = 0;
            mdl_in_row++;
        end
        if (eof) restart_counters();
    endtask

    // Offer one item, after a random idle burst unless idling is off, and hold it
    // until the block takes it. Valid is left high for a following item.
    task automatic offer(input logic [PIX_W-1:0] pix, input logic drn,
                         output bit taken, output bit produced, output blur_item_t res);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= pix;
        drain    <= drn;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        blur_predict(pix, drn, taken, produced, res);
    endtask

    task automatic feed(input logic [PIX_W-1:0] pix, input logic drn);
        bit taken, produced;
        blur_item_t res;
        offer(pix, drn, taken, produced, res);
        if (produced) pending_q.push_back(res);
        if (taken) rand_items++;
    endtask

    // Drop valid, wait for every owed item, then let the pipeline run dry.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; valid stays high so writes can follow back to back.
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_IMAGE_WIDTH) begin
            mdl_width = data[WIDTH_W-1:0];
            restart_counters();
        end else if (idx == CFG_IMAGE_HEIGHT) begin
            mdl_height = data[HEIGHT_W-1:0];
            restart_counters();
        end
    endtask

    // Result side: check each item taken against the oldest one owed, then pick
    // the next ready level (long hold-off, idle burst, or ready).
    initial begin : result_sink
        blur_item_t want;
        int gap_left;
        int hold_left;
        gap_left  = 0;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_q.size() == 0) begin
                    $error("unexpected item: pixel_out %0d end_of_frame %0b",
                           pixel_out, end_of_frame);
                    err_count++;
                end else begin
                    want = pending_q.pop_front();
                    if (pixel_out !== want.pix) begin
                        $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
                        err_count++;
                    end
                    if (end_of_frame !== want.eof) begin
                        $error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
                        err_count++;
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                out_ready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 5) == 0) begin
                gap_left  = $urandom_range(0, 14);
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb_top: done, errors");
        $finish;
    end

    initial begin : stimulus
        bit taken, produced, broken;
        blur_item_t res;
        int i, phase, f, j, len, frame_len, n_frames, fw, fh;
        logic [CFG_DATA_W-1:0] w_data, h_data;

        // Hold reset for a fixed stretch, then release it once.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table: register writes only once the block has gone quiet.
        for (i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].kind == ROW_REG) begin
                if (i == 0 || DIRECTED[i-1].kind != ROW_REG) settle();
                reg_write(DIRECTED[i].idx, DIRECTED[i].data);
            end else begin
                if (i > 0 && DIRECTED[i-1].kind == ROW_REG) cfg_valid <= 1'b0;
                offer(DIRECTED[i].pix, DIRECTED[i].drn, taken, produced, res);
                if (DIRECTED[i].kind == ROW_KNOWN)
                    pending_q.push_back(blur_item_t'{pix: DIRECTED[i].want_pix,
                                                     eof: DIRECTED[i].want_eof});
                else if (produced)
                    pending_q.push_back(res);
            end
        end

        // Random phases. The first three take the size extremes: the widest row
        // (written as 2047, clamped), then the tallest heights as partial frames.
        // Phase three fixes a mid-size frame for the long receiver hold-off.
        phase = 0;
        while (phase < 3 || rand_items < RANDOM_ITEMS) begin
            if (phase == 3) rand_items = 0;
            case (phase)
                0: begin w_data = 13'h07FF; h_data = 13'd1;    end
                1: begin w_data = 13'd1;    h_data = 13'h1000; end
                2: begin w_data = 13'd2;    h_data = 13'h1FFF; end
                3: begin w_data = 13'd8;    h_data = 13'd6;    end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       fw = 0;
                        1:       fw = $urandom_range(13, 64);
                        default: fw = $urandom_range(1, 12);
                    endcase
                    if (fw > 12)                     fh = $urandom_range(1, 3);
                    else if ($urandom_range(0, 7) == 0) fh = 0;
                    else                             fh = $urandom_range(1, 8);
                    // bits above the width field are junk and must be dropped
                    w_data = {2'($urandom_range(0, 3)), 11'(fw)};
                    h_data = 13'(fh);
                end
            endcase

            settle();
            if ($urandom_range(0, 1) == 1) begin
                reg_write(CFG_IMAGE_HEIGHT, h_data);
                reg_write(CFG_IMAGE_WIDTH, w_data);
            end else begin
                reg_write(CFG_IMAGE_WIDTH, w_data);
                reg_write(CFG_IMAGE_HEIGHT, h_data);
            end
            cfg_valid <= 1'b0;

            // Keep the tail free of idling; now and then run a whole phase without gaps.
            no_idle = (phase >= 3 && rand_items >= TAIL_START) || ($urandom_range(0, 4) == 0);
            if (phase == 3) hold_req = 1'b1;

            fw        = cur_width();
            fh        = cur_height();
            frame_len = fw * fh + fw + 1;
            n_frames  = (phase < 3) ? 1 : $urandom_range(1, 3);
            if (phase == 4) n_frames = 2;
            broken    = (phase >= 4) && ($urandom_range(0, 5) == 0);

            for (f = 0; f < n_frames; f++) begin
                len = frame_len;
                if (phase == 1)
                    len = 40;
                else if (phase == 2)
                    len = 60;
                else if (broken && f == n_frames - 1)
                    len = $urandom_range(1, frame_len - 1);
                for (j = 0; j < len; j++) begin
                    if (j < fw * fh) begin
                        // stray drain among the pixels: the block should drop it
                        if ($urandom_range(0, 19) == 0) feed(pick_pixel(), 1'b1);
                        feed(pick_pixel(), 1'b0);
                    end else if ($urandom_range(0, 5) == 0) begin
                        // pixel during the flush counts as a drain
                        feed(pick_pixel(), 1'b0);
                    end else begin
                        feed(pick_pixel(), 1'b1);
                    end
                end
                // spare drain after the frame has closed: ignored
                if (len == frame_len && $urandom_range(0, 7) == 0) feed(pick_pixel(), 1'b1);
                // pause the sender until every owed item is back
                if (f + 1 < n_frames && (phase == 4 || $urandom_range(0, 3) == 0)) settle();
            end
            phase++;
        end

        settle();
        if (err_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
